FILE: design/gfjs_pkg.sv
// ----------------------------------------------------------------------------
// gfjs_pkg: shared definitions for the grouped FIFO job scheduler
// Function codes, status codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package gfjs_pkg;

    localparam int unsigned DefGroups  = 8;
    localparam int unsigned DefEntries = 64;
    localparam int unsigned DefJobBits = 8;

    localparam logic [1:0] FUNC_ENQ  = 2'd0;
    localparam logic [1:0] FUNC_PICK = 2'd1;
    localparam logic [1:0] FUNC_MARK = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POOL_FULL = 2'd1;
    localparam logic [1:0] ST_TBL_FULL  = 2'd2;

    localparam logic REG_PRIO_MODE  = 1'b0;
    localparam logic REG_BASE_SLICE = 1'b1;

endpackage

FILE: design/grouped_fifo_job_scheduler.sv
// ----------------------------------------------------------------------------
// grouped_fifo_job_scheduler: round-robin scheduler over per-group job FIFOs
// Groups sorted by id, FIFO entries drawn from a shared linked-list pool.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_valid / o_stall): one transaction is a command: enqueue,
//  pick or start mark. Output channel (o_valid / i_stall): one result per
//  command. Config channel (i_cfg_valid / o_cfg_ready): register index and data.
//  A start mark, a resume or an unused code goes straight to the result.
//  Enqueue searches the group table one slot per cycle, then pops the pool
//  and updates the links; a new group adds a table shift of one slot per
//  cycle down to the insert slot. Pick reads each popped FIFO entry, then
//  its start mark, then checks it, until an unstarted job shows up or the
//  FIFO drains; in priority mode a found job's slice is then scaled by the
//  one 32x8 multiplier.
//  Only one command is in flight; o_stall is high from acceptance until the
//  result has been taken, and the result register holds steady while the
//  receiver stalls. The next command can be accepted the cycle after.
//  Reset: group 0 exists, all FIFOs empty. The pool free list is chained and
//  the start marks are cleared by a sweep after reset, during which no
//  command is accepted.
// ----------------------------------------------------------------------------
module grouped_fifo_job_scheduler
    import gfjs_pkg::*;
#(
    parameter int unsigned GROUPS   = DefGroups,
    parameter int unsigned ENTRIES  = DefEntries,
    parameter int unsigned JOB_BITS = DefJobBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_job_id,
    input  logic [15:0] i_group_id,
    input  logic [7:0]  i_group_prio,
    input  logic        i_last_valid,
    input  logic        i_last_finished,
    input  logic [7:0]  i_last_job,
    input  logic [31:0] i_slice_in,
    input  logic [31:0] i_switch_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_job_found,
    output logic [7:0]  o_picked_job,
    output logic        o_resumed,
    output logic [39:0] o_slice_out,
    output logic [31:0] o_switch_out,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int unsigned GC = $clog2(GROUPS + 1);
    localparam int unsigned EW = $clog2(ENTRIES);
    localparam int unsigned EC = $clog2(ENTRIES + 1);
    localparam int unsigned NJ = 1 << JOB_BITS;
    localparam int unsigned INIT_N = (NJ > ENTRIES) ? NJ : ENTRIES;
    localparam int unsigned IW = $clog2(INIT_N + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SRCH, S_CHK, S_SHIFT, S_ALLOC, S_LINK,
        S_PSEL, S_PRD, S_PMK, S_PCHK, S_MUL, S_DONE
    } t_state;

    t_state          r_state;
    logic            r_prio_mode;
    logic [31:0]     r_base_slice;

    // group table (register file)
    logic [15:0]     r_gid  [GROUPS];
    logic [EW-1:0]   r_ghd  [GROUPS];
    logic [EW-1:0]   r_gtl  [GROUPS];
    logic            r_gvld [GROUPS];
    logic [GC-1:0]   r_gcnt;
    logic [GW-1:0]   r_rr;

    // entry pool memory
    logic [7:0]      m_job  [ENTRIES];
    logic [7:0]      m_prio [ENTRIES];
    logic [EW-1:0]   m_link [ENTRIES];
    logic [EW-1:0]   r_free_head;
    logic [EC-1:0]   r_free_cnt;
    logic [7:0]      r_rd_job, r_rd_prio;
    logic [EW-1:0]   r_rd_link;

    // start-mark memory, one registered read of the popped job per cycle
    logic            r_mark [NJ];
    logic            r_rd_mark;

    // command registers
    logic [7:0]      r_job, r_prio;
    logic [15:0]     r_grp;

    logic [GC-1:0]   r_idx;
    logic [GW-1:0]   r_slot;
    logic            r_hit;
    logic [GC-1:0]   r_pos;
    logic            r_pos_set;
    logic [EW-1:0]   r_cur;
    logic [IW-1:0]   r_init;

    logic            r_ovld;
    logic            r_found, r_res;
    logic [7:0]      r_pick;
    logic [39:0]     r_slo;
    logic [31:0]     r_swo;
    logic [1:0]      r_st;

    logic [GW-1:0]   w_idx;
    logic [GW-1:0]   w_nxt;

    assign w_idx  = r_idx[GW-1:0];
    assign w_nxt  = (GC'(r_rr) + GC'(1) >= r_gcnt) ? '0 : GW'(r_rr + 1'b1);

    assign o_stall      = (r_state != S_IDLE) || r_ovld;
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_ovld;
    assign o_job_found  = r_found;
    assign o_picked_job = r_pick;
    assign o_resumed    = r_res;
    assign o_slice_out  = r_slo;
    assign o_switch_out = r_swo;
    assign o_status     = r_st;

    // entry and mark memories: one write port and one registered read per array
    always_ff @(posedge i_clk) begin
        r_rd_job  <= m_job[r_cur];
        r_rd_prio <= m_prio[r_cur];
        r_rd_link <= m_link[r_cur];
        r_rd_mark <= r_mark[JOB_BITS'(r_rd_job)];
        if (r_state == S_INIT) begin
            if (r_init < IW'(ENTRIES)) begin
                m_link[r_init[EW-1:0]] <= (r_init[EW-1:0] == EW'(ENTRIES - 1)) ? '0
                                          : EW'(r_init[EW-1:0] + 1'b1);
            end
        end else if (r_state == S_ALLOC) begin
            m_job[r_free_head]  <= r_job;
            m_prio[r_free_head] <= r_prio;
        end else if (r_state == S_LINK && r_gvld[r_slot]) begin
            m_link[r_gtl[r_slot]] <= r_cur;
        end else if (r_state == S_PCHK) begin
            m_link[r_cur] <= r_free_head;
        end
        if (r_state == S_INIT) begin
            if (r_init < IW'(NJ)) r_mark[r_init[JOB_BITS-1:0]] <= 1'b0;
        end else if (r_state == S_IDLE && i_valid && !r_ovld && i_func == FUNC_MARK) begin
            r_mark[JOB_BITS'(i_job_id)] <= 1'b1;
        end else if (r_state == S_LINK) begin
            // a queued job has not started
            r_mark[JOB_BITS'(r_job)] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_prio_mode <= 1'b0;
            r_base_slice <= '0;
            for (int i = 0; i < GROUPS; i++) begin
                r_gid[i]  <= '0;
                r_gvld[i] <= 1'b0;
            end
            r_gcnt      <= GC'(1);
            r_rr        <= '0;
            r_free_head <= '0;
            r_free_cnt  <= EC'(ENTRIES);
            r_init      <= '0;
            r_ovld      <= 1'b0;
            r_cur       <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_PRIO_MODE) r_prio_mode <= i_cfg_data[0];
                else                              r_base_slice <= i_cfg_data;
            end
            if (r_ovld && !i_stall) r_ovld <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_init <= r_init + 1'b1;
                    if (r_init == IW'(INIT_N - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && !r_ovld) begin
                        r_job <= i_job_id; r_grp <= i_group_id;
                        r_prio <= i_group_prio;
                        r_found <= 1'b0; r_res <= 1'b0; r_pick <= '0;
                        r_slo <= '0; r_swo <= '0; r_st <= ST_OK;
                        r_idx <= '0; r_hit <= 1'b0; r_pos <= r_gcnt; r_pos_set <= 1'b0;
                        case (i_func)
                            FUNC_ENQ: r_state <= S_SRCH;
                            FUNC_MARK: r_state <= S_DONE;
                            FUNC_PICK: begin
                                r_slo <= 40'(i_slice_in);
                                if (i_last_valid && !i_last_finished) begin
                                    r_found <= 1'b1; r_res <= 1'b1; r_pick <= i_last_job;
                                    r_state <= S_DONE;
                                end else begin
                                    r_swo <= i_switch_in;
                                    r_state <= S_PSEL;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SRCH: begin
                    // one slot per cycle: find match and insert position
                    if (r_idx >= r_gcnt) begin
                        r_state <= S_CHK;
                    end else begin
                        if (r_gid[w_idx] == r_grp && !r_hit) begin
                            r_hit <= 1'b1; r_slot <= w_idx;
                        end
                        if (r_gid[w_idx] > r_grp && !r_pos_set) begin
                            r_pos_set <= 1'b1; r_pos <= r_idx;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_CHK: begin
                    // start the link read of the free head
                    r_cur <= r_free_head;
                    if (!r_hit && r_gcnt >= GC'(GROUPS)) begin
                        r_st <= ST_TBL_FULL; r_state <= S_DONE;
                    end else if (r_free_cnt == '0) begin
                        r_st <= ST_POOL_FULL; r_state <= S_DONE;
                    end else if (r_hit) begin
                        r_state <= S_ALLOC;
                    end else begin
                        r_idx <= r_gcnt;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    // move slots up one per cycle down to the insert position
                    if (r_idx > r_pos) begin
                        r_gid[w_idx]  <= r_gid[GW'(r_idx - 1'b1)];
                        r_ghd[w_idx]  <= r_ghd[GW'(r_idx - 1'b1)];
                        r_gtl[w_idx]  <= r_gtl[GW'(r_idx - 1'b1)];
                        r_gvld[w_idx] <= r_gvld[GW'(r_idx - 1'b1)];
                        r_idx <= r_idx - 1'b1;
                    end else begin
                        r_gid[GW'(r_pos)]  <= r_grp;
                        r_gvld[GW'(r_pos)] <= 1'b0;
                        if (GC'(r_rr) >= r_pos) r_rr <= GW'(r_rr + 1'b1);
                        r_gcnt <= r_gcnt + 1'b1;
                        r_slot <= GW'(r_pos);
                        r_state <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    // entry write; link of the free head is read this edge
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    // r_rd_link now holds link of the allocated entry
                    r_free_head <= r_rd_link;
                    r_free_cnt  <= r_free_cnt - 1'b1;
                    if (!r_gvld[r_slot]) r_ghd[r_slot] <= r_cur;
                    r_gtl[r_slot]  <= r_cur;
                    r_gvld[r_slot] <= 1'b1;
                    r_state <= S_DONE;
                end
                S_PSEL: begin
                    r_rr <= w_nxt; r_slot <= w_nxt;
                    r_cur <= r_ghd[w_nxt];
                    r_state <= r_gvld[w_nxt] ? S_PRD : S_DONE;
                end
                S_PRD: r_state <= S_PMK;
                S_PMK: r_state <= S_PCHK;
                S_PCHK: begin
                    // pop head, return it to the free list
                    if (r_cur == r_gtl[r_slot]) r_gvld[r_slot] <= 1'b0;
                    else r_ghd[r_slot] <= r_rd_link;
                    r_free_head <= r_cur;
                    r_free_cnt  <= r_free_cnt + 1'b1;
                    if (!r_rd_mark) begin
                        r_found <= 1'b1; r_pick <= r_rd_job;
                        r_state <= r_prio_mode ? S_MUL : S_DONE;
                    end else if (r_cur == r_gtl[r_slot]) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cur <= r_rd_link;
                        r_state <= S_PRD;
                    end
                end
                S_MUL: begin
                    r_slo <= 40'(r_base_slice) * 40'(r_rd_prio);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_ovld <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // free count never exceeds the pool
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= EC'(ENTRIES)) else $error("free count overflow");
    // group count stays within table
    a_grp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gcnt >= GC'(1) && r_gcnt <= GC'(GROUPS)) else $error("group count");
    // rr pointer stays within groups
    a_rr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        GC'(r_rr) < r_gcnt) else $error("rr pointer out of range");
    // a result appears only after the done step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> $past(r_state) == S_DONE) else $error("stray result");

endmodule

FILE: tb/sv/grouped_fifo_job_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grouped_fifo_job_scheduler_tb: self-checking bench for the job scheduler
// Drives enqueue, pick and start-mark commands with random gaps and stalls,
// predicts every result with a behavioral copy of the group table and pool,
// and compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module grouped_fifo_job_scheduler_tb;
    import gfjs_pkg::*;

    localparam int NGRP = 8;
    localparam int NENT = 64;
    localparam int NJOB = 256;

    typedef struct packed {
        logic        found;
        logic [7:0]  job;
        logic        resumed;
        logic [39:0] slice;
        logic [31:0] switch_t;
        logic [1:0]  status;
    } t_sched_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func = FUNC_ENQ;
    logic [7:0]  i_job_id = '0;
    logic [15:0] i_group_id = '0;
    logic [7:0]  i_group_prio = '0;
    logic        i_last_valid = 1'b0;
    logic        i_last_finished = 1'b0;
    logic [7:0]  i_last_job = '0;
    logic [31:0] i_slice_in = '0;
    logic [31:0] i_switch_in = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_job_found;
    logic [7:0]  o_picked_job;
    logic        o_resumed;
    logic [39:0] o_slice_out;
    logic [31:0] o_switch_out;
    logic [1:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = REG_PRIO_MODE;
    logic [31:0] i_cfg_data = '0;

    grouped_fifo_job_scheduler u_dut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state: mirrors the group table, entry pool and start marks
    logic [15:0] gp_id   [NGRP];
    logic [5:0]  gp_head [NGRP];
    logic [5:0]  gp_tail [NGRP];
    logic        gp_busy [NGRP];
    int          gp_num;
    logic [7:0]  pool_job  [NENT];
    logic [7:0]  pool_prio [NENT];
    logic [5:0]  pool_next [NENT];
    logic [5:0]  free_top;
    int          free_num;
    logic        job_started [NJOB];
    int          rr_ptr;
    logic        cfg_prio;
    logic [31:0] cfg_base;

    t_sched_result expected_q[$];
    int  n_fail = 0;
    bit  stall_rand = 1'b1;
    int  stall_cnt = 0;

    task automatic model_reset();
        for (int i = 0; i < NGRP; i++) begin
            gp_id[i] = '0; gp_head[i] = '0; gp_tail[i] = '0; gp_busy[i] = 1'b0;
        end
        for (int i = 0; i < NENT; i++) begin
            pool_next[i] = 6'(i + 1); pool_job[i] = '0; pool_prio[i] = '0;
        end
        for (int i = 0; i < NJOB; i++) job_started[i] = 1'b0;
        gp_num = 1; free_top = '0; free_num = NENT; rr_ptr = 0;
        cfg_prio = 1'b0; cfg_base = '0;
    endtask

    function automatic logic [1:0] model_enqueue(logic [7:0] job, logic [15:0] gid,
                                                 logic [7:0] prio);
        int slot, pos;
        logic [5:0] e;
        slot = NGRP;
        for (int i = 0; i < gp_num; i++)
            if (gp_id[i] == gid) begin slot = i; break; end
        if (slot == NGRP && gp_num >= NGRP) return ST_TBL_FULL;
        if (free_num == 0) return ST_POOL_FULL;
        if (slot == NGRP) begin
            // sorted insert; shift later slots up by one
            pos = gp_num;
            for (int i = 0; i < gp_num; i++)
                if (gp_id[i] > gid) begin pos = i; break; end
            for (int i = gp_num; i > pos; i--) begin
                gp_id[i] = gp_id[i-1]; gp_head[i] = gp_head[i-1];
                gp_tail[i] = gp_tail[i-1]; gp_busy[i] = gp_busy[i-1];
            end
            gp_id[pos] = gid; gp_head[pos] = '0; gp_tail[pos] = '0; gp_busy[pos] = 1'b0;
            if (rr_ptr >= pos) rr_ptr++;
            gp_num++;
            slot = pos;
        end
        e = free_top;
        free_top = pool_next[e];
        free_num--;
        pool_job[e] = job; pool_prio[e] = prio;
        if (gp_busy[slot]) pool_next[gp_tail[slot]] = e;
        else gp_head[slot] = e;
        gp_tail[slot] = e;
        gp_busy[slot] = 1'b1;
        job_started[job] = 1'b0;
        return ST_OK;
    endfunction

    function automatic t_sched_result model_command(logic [1:0] fn, logic [7:0] job,
            logic [15:0] gid, logic [7:0] prio, logic lv, logic lf, logic [7:0] lj,
            logic [31:0] sl, logic [31:0] sw);
        t_sched_result r;
        int s;
        logic [5:0] e;
        r = '0;
        if (fn == FUNC_ENQ) begin
            r.status = model_enqueue(job, gid, prio);
        end else if (fn == FUNC_MARK) begin
            job_started[job] = 1'b1;
        end else if (fn == FUNC_PICK) begin
            if (lv && !lf) begin
                r.found = 1'b1; r.job = lj; r.resumed = 1'b1; r.slice = 40'(sl);
            end else begin
                r.slice = 40'(sl); r.switch_t = sw;
                s = rr_ptr + 1;
                if (s >= gp_num) s = 0;
                rr_ptr = s;
                // pop until an unstarted job shows up or the FIFO drains
                while (gp_busy[s]) begin
                    e = gp_head[s];
                    if (e == gp_tail[s]) gp_busy[s] = 1'b0;
                    else gp_head[s] = pool_next[e];
                    pool_next[e] = free_top; free_top = e; free_num++;
                    if (!job_started[pool_job[e]]) begin
                        r.found = 1'b1; r.job = pool_job[e];
                        if (cfg_prio) r.slice = 40'(cfg_base) * 40'(pool_prio[e]);
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    // Send one command transaction and queue its predicted result.
    // Valid stays up after acceptance until the next gap or drain drops it.
    task automatic send_cmd(logic [1:0] fn, logic [7:0] job, logic [15:0] gid,
            logic [7:0] prio, logic lv, logic lf, logic [7:0] lj,
            logic [31:0] sl, logic [31:0] sw);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1; i_func <= fn; i_job_id <= job; i_group_id <= gid;
        i_group_prio <= prio; i_last_valid <= lv; i_last_finished <= lf;
        i_last_job <= lj; i_slice_in <= sl; i_switch_in <= sw;
        do @(posedge i_clk); while (o_stall);
        expected_q.push_back(model_command(fn, job, gid, prio, lv, lf, lj, sl, sw));
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_PRIO_MODE) cfg_prio = val[0];
        else cfg_base = val;
    endtask

    task automatic set_config(logic pm, logic [31:0] base);
        wait_drain();
        write_reg(REG_PRIO_MODE, {31'd0, pm});
        write_reg(REG_BASE_SLICE, base);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_enq(logic [7:0] job, logic [15:0] gid, logic [7:0] prio);
        send_cmd(FUNC_ENQ, job, gid, prio, 1'b0, 1'b0, 8'($urandom),
                 $urandom, $urandom);
    endtask

    task automatic send_pick(logic lv, logic lf);
        send_cmd(FUNC_PICK, 8'($urandom), 16'($urandom), 8'($urandom), lv, lf,
                 8'($urandom), $urandom, $urandom);
    endtask

    // Directed: field extremes, every function, resume, marks, table full
    task automatic test_directed();
        set_config(1'b1, 32'hFFFF_FFFF);
        send_enq(8'hFF, 16'hFFFF, 8'hFF);       // largest id goes at the tail
        send_enq(8'h00, 16'h0000, 8'h00);
        send_enq(8'h12, 16'h0005, 8'h01);       // insert between existing groups
        send_cmd(FUNC_MARK, 8'h12, '0, '0, 1'b0, 1'b0, '0, '0, '0);
        send_pick(1'b1, 1'b0);                  // resume of the last job
        send_pick(1'b1, 1'b1);
        send_pick(1'b0, 1'b0);
        send_pick(1'b0, 1'b1);
        send_pick(1'b0, 1'b0);                  // empty group, no job found
        send_pick(1'b0, 1'b0);
        send_cmd(2'd3, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'hFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF); // unused code
        for (int g = 1; g <= 8; g++) send_enq(8'(g), 16'(g * 100), 8'(g));
        wait_drain();
        for (int k = 0; k < 60; k++) send_enq(8'(k), 16'(100 * ($urandom_range(0, 6))),
                                              8'($urandom));
        for (int k = 0; k < 70; k++) send_pick(1'b0, 1'b1);
    endtask

    // Random: mostly enqueue/pick over a few groups, some marks and odd codes
    task automatic test_random(int n, logic [15:0] id_span);
        int sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                send_enq(8'($urandom), 16'($urandom_range(0, id_span)), 8'($urandom));
            else if (sel < 85)
                send_pick(1'($urandom), 1'($urandom_range(0, 3) != 0));
            else if (sel < 97)
                send_cmd(FUNC_MARK, 8'($urandom), 16'($urandom), 8'($urandom),
                         1'($urandom), 1'($urandom), 8'($urandom), $urandom, $urandom);
            else
                send_cmd(2'd3, 8'($urandom), 16'($urandom), 8'($urandom),
                         1'($urandom), 1'($urandom), 8'($urandom), $urandom, $urandom);
            if (k == n / 2) wait_drain();       // sender holds off until drained
        end
    endtask

    // Receiver side: per result, stall a drawn number of cycles, then take it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_cnt = 0;
        end else if (o_valid && !i_stall) begin
            stall_cnt = stall_rand ? $urandom_range(0, 10) : 0;
            i_stall <= (stall_cnt != 0);
        end else if (o_valid && stall_cnt != 0) begin
            stall_cnt--;
            i_stall <= (stall_cnt != 0);
        end
    end

    always @(posedge i_clk) begin
        t_sched_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $error("result with no pending command");
                n_fail++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_job_found !== exp_r.found) begin
                    $error("job_found exp %0h got %0h", exp_r.found, o_job_found); n_fail++;
                end
                if (o_picked_job !== exp_r.job) begin
                    $error("picked_job exp %0h got %0h", exp_r.job, o_picked_job); n_fail++;
                end
                if (o_resumed !== exp_r.resumed) begin
                    $error("resumed exp %0h got %0h", exp_r.resumed, o_resumed); n_fail++;
                end
                if (o_slice_out !== exp_r.slice) begin
                    $error("slice_out exp %0h got %0h", exp_r.slice, o_slice_out); n_fail++;
                end
                if (o_switch_out !== exp_r.switch_t) begin
                    $error("switch_out exp %0h got %0h", exp_r.switch_t, o_switch_out);
                    n_fail++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status exp %0h got %0h", exp_r.status, o_status); n_fail++;
                end
            end
        end
    end

    initial begin
        model_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        set_config(1'b0, 32'd0);
        test_random(100, 16'd7);
        set_config(1'b1, 32'h0001_0000);
        stall_rand = 1'b0;                      // a stretch with no receiver stalls
        test_random(80, 16'hFFFF);
        stall_rand = 1'b1;
        set_config(1'b1, 32'hFFFF_FFFF);
        test_random(100, 16'd20);
        set_config(1'b0, 32'h1234_5678);
        test_random(70, 16'd3);
        wait_drain();
        if (expected_q.size() == 0 && n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
design/gfjs_pkg.sv
design/grouped_fifo_job_scheduler.sv
tb/sv/grouped_fifo_job_scheduler_tb.sv
